// ----- sv/ffba_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and codes of the first-fit block allocator.
package ffba_pkg;

  localparam int MAX_BLOCKS     = 16;
  localparam int OVERHEAD_BYTES = 24;
  localparam int IDX_W          = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CNT_W          = $clog2(MAX_BLOCKS + 1);
  localparam int QUEUE_DEPTH    = 2;
  localparam int QPTR_W         = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_NO_SPACE  = 2'd1;
  localparam logic [1:0] STATUS_ZERO_SIZE = 2'd2;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd3;

  typedef enum logic [1:0] {
    CLS_ALLOC,
    CLS_ZERO,
    CLS_FREE
  } ffba_cls_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MATCH,
    ST_RESOLVE
  } ffba_state_e;

  typedef struct packed {
    logic        operation;
    logic [23:0] request_size;
    logic [31:0] address;
  } ffba_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] data_address;
  } ffba_rsp_t;

  typedef struct packed {
    ffba_cls_e   cls;
    logic [23:0] size;
    logic [31:0] addr;
  } ffba_cmd_t;

endpackage

// ----- sv/first_fit_block_allocator.sv -----
`timescale 1ns / 1ps
// Top level of the first-fit block allocator: register port, front end and back end.
//
// Requests enter on req_valid_i / req_stall_o / req_i; an item is taken at a
// clock edge with req_valid_i high and req_stall_o low. Each request gives
// exactly one result on rsp_valid_o / rsp_stall_i / rsp_o, in request order.
// An allocate of a nonzero size reuses the first free block in table order
// that is large enough, else appends a block from the bump pointer; a free
// marks the block whose data address matches.
// With an empty queue, a request passes through the queue, the work register,
// the match registers and the result register. The back end runs its
// match-then-resolve sequence over the block table one request at a time.
// A two-entry queue sits between front and back, so requests are taken while
// a result waits; once it fills, req_stall_o rises. While a result is valid and
// rsp_stall_i is high, the result register holds its item and the back end waits.
// Reset empties the table, the queue and the result register, and clears
// heap_base and heap_size to 0. Write heap_base (address 0) and heap_size
// (address 4) over the register port only while no request is in flight.
module first_fit_block_allocator (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  input  logic                req_valid_i,
  output logic                req_stall_o,
  input  ffba_pkg::ffba_req_t req_i,
  output logic                rsp_valid_o,
  input  logic                rsp_stall_i,
  output ffba_pkg::ffba_rsp_t rsp_o
);
  import ffba_pkg::*;

  logic [31:0] heap_base_q;
  logic [23:0] heap_size_q;
  logic        cfg_write;
  logic        cmd_valid;
  logic        cmd_pop;
  ffba_cmd_t   cmd;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = paddr[2] ? {8'b0, heap_size_q} : heap_base_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_base_q <= '0;
      heap_size_q <= '0;
    end else if (cfg_write) begin
      if (paddr[2]) begin
        heap_size_q <= pwdata[23:0];
      end else begin
        heap_base_q <= pwdata;
      end
    end
  end

  ffba_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid_i),
    .req_stall_o (req_stall_o),
    .req_i       (req_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  ffba_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .heap_base_i (heap_base_q),
    .heap_size_i (heap_size_q),
    .rsp_valid_o (rsp_valid_o),
    .rsp_stall_i (rsp_stall_i),
    .rsp_o       (rsp_o)
  );

endmodule

// ----- sv/ffba_front.sv -----
`timescale 1ns / 1ps
// Front end: accepts request items, classifies them and queues them for the back end.
module ffba_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_stall_o,
  input  ffba_pkg::ffba_req_t req_i,
  output logic              cmd_valid_o,
  output ffba_pkg::ffba_cmd_t cmd_o,
  input  logic              cmd_pop_i
);
  import ffba_pkg::*;

  ffba_cmd_t         q_mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              push;
  logic              pop;
  ffba_cmd_t         cmd_new;

  assign req_stall_o = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign push        = req_valid_i && !req_stall_o;
  assign cmd_valid_o = (cnt_q != '0);
  assign pop         = cmd_pop_i && cmd_valid_o;
  assign cmd_o       = q_mem_q[rd_ptr_q];

  always_comb begin
    cmd_new.size = req_i.request_size;
    cmd_new.addr = req_i.address;
    if (req_i.operation == OP_FREE) begin
      cmd_new.cls = CLS_FREE;
    end else if (req_i.request_size == '0) begin
      cmd_new.cls = CLS_ZERO;
    end else begin
      cmd_new.cls = CLS_ALLOC;
    end
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

// ----- sv/ffba_back.sv -----
`timescale 1ns / 1ps
// Back end: block table, first-fit match, bump allocation and result register.
module ffba_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  input  ffba_pkg::ffba_cmd_t cmd_i,
  output logic                cmd_pop_o,
  input  logic [31:0]         heap_base_i,
  input  logic [23:0]         heap_size_i,
  output logic                rsp_valid_o,
  input  logic                rsp_stall_i,
  output ffba_pkg::ffba_rsp_t rsp_o
);
  import ffba_pkg::*;

  ffba_state_e           state_q, state_d;
  ffba_cmd_t             work_q;
  logic [MAX_BLOCKS-1:0] hit_q, hit_d;
  logic                  no_space_q, no_space_d;
  logic [31:0]           new_data_q, new_data_d;
  logic [24:0]           need_q, need_d;

  logic [23:0]           entry_size_q [MAX_BLOCKS];
  logic [31:0]           entry_data_q [MAX_BLOCKS];
  logic [MAX_BLOCKS-1:0] entry_free_q, entry_free_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [23:0]           used_q, used_d;

  logic                  rsp_valid_q;
  ffba_rsp_t             rsp_q, rsp_d;

  logic                  load_work;
  logic                  load_match;
  logic                  resolve_fire;
  logic                  hit_any;
  logic [IDX_W-1:0]      hit_idx;
  logic                  append;
  logic [23:0]           remaining;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          state_d = ST_MATCH;
        end
      end
      ST_MATCH: begin
        state_d = ST_RESOLVE;
      end
      ST_RESOLVE: begin
        if (!rsp_valid_q || !rsp_stall_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    load_work    = 1'b0;
    load_match   = 1'b0;
    resolve_fire = 1'b0;
    case (state_q)
      ST_IDLE:    load_work    = cmd_valid_i;
      ST_MATCH:   load_match   = 1'b1;
      ST_RESOLVE: resolve_fire = !rsp_valid_q || !rsp_stall_i;
      default:    load_work    = 1'b0;
    endcase
  end

  assign cmd_pop_o = load_work;

  always_comb begin
    for (int i = 0; i < MAX_BLOCKS; i++) begin
      if (CNT_W'(i) < count_q) begin
        if (work_q.cls == CLS_FREE) begin
          hit_d[i] = (entry_data_q[i] == work_q.addr);
        end else begin
          hit_d[i] = entry_free_q[i] && (entry_size_q[i] >= work_q.size);
        end
      end else begin
        hit_d[i] = 1'b0;
      end
    end
    remaining  = (heap_size_i > used_q) ? heap_size_i - used_q : '0;
    need_d     = {1'b0, work_q.size} + 25'(OVERHEAD_BYTES);
    no_space_d = need_d > {1'b0, remaining};
    new_data_d = heap_base_i + {8'b0, used_q} + 32'(OVERHEAD_BYTES);
  end

  always_comb begin
    hit_any = 1'b0;
    hit_idx = '0;
    for (int i = MAX_BLOCKS - 1; i >= 0; i--) begin
      if (hit_q[i]) begin
        hit_any = 1'b1;
        hit_idx = IDX_W'(i);
      end
    end
  end

  always_comb begin
    rsp_d              = '0;
    rsp_d.status       = STATUS_OK;
    entry_free_d       = entry_free_q;
    count_d            = count_q;
    used_d             = used_q;
    append             = 1'b0;
    case (work_q.cls)
      CLS_ZERO: begin
        rsp_d.status = STATUS_ZERO_SIZE;
      end
      CLS_FREE: begin
        if (hit_any) begin
          entry_free_d[hit_idx] = 1'b1;
        end else begin
          rsp_d.status = STATUS_NOT_FOUND;
        end
      end
      CLS_ALLOC: begin
        if (hit_any) begin
          entry_free_d[hit_idx] = 1'b0;
          rsp_d.data_address    = entry_data_q[hit_idx];
        end else if (count_q >= CNT_W'(MAX_BLOCKS) || no_space_q) begin
          rsp_d.status = STATUS_NO_SPACE;
        end else begin
          append                                  = 1'b1;
          entry_free_d[count_q[IDX_W-1:0]]        = 1'b0;
          rsp_d.data_address                      = new_data_q;
          count_d                                 = count_q + 1'b1;
          used_d                                  = used_q + need_q[23:0];
        end
      end
      default: begin
        rsp_d.status = STATUS_NOT_FOUND;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      entry_free_q <= '0;
      count_q      <= '0;
      used_q       <= '0;
      rsp_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (resolve_fire) begin
        entry_free_q <= entry_free_d;
        count_q      <= count_d;
        used_q       <= used_d;
        rsp_valid_q  <= 1'b1;
      end else if (!rsp_stall_i) begin
        rsp_valid_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_work) begin
      work_q <= cmd_i;
    end
    if (load_match) begin
      hit_q      <= hit_d;
      no_space_q <= no_space_d;
      need_q     <= need_d;
      new_data_q <= new_data_d;
    end
    if (resolve_fire) begin
      rsp_q <= rsp_d;
    end
    if (resolve_fire && append) begin
      entry_size_q[count_q[IDX_W-1:0]] <= work_q.size;
      entry_data_q[count_q[IDX_W-1:0]] <= new_data_q;
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule

// ----- sv/ffba_checker.sv -----
`timescale 1ns / 1ps
// Port-level checker for the first-fit block allocator and its bind.
module ffba_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                pready,
  input logic                req_stall_o,
  input logic                rsp_valid_o,
  input logic                rsp_stall_i,
  input ffba_pkg::ffba_rsp_t rsp_o
);
  import ffba_pkg::*;

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && rsp_stall_i |=> rsp_valid_o && $stable(rsp_o))
    else $error("result item changed while stalled");

  a_fail_zero_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && (rsp_o.status != STATUS_OK) |-> rsp_o.data_address == '0)
    else $error("failed result carries a data address");

  a_reset_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !rsp_valid_o && !req_stall_o && pready)
    else $error("block not empty after reset");

endmodule

bind first_fit_block_allocator ffba_checker u_ffba_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .pready      (pready),
  .req_stall_o (req_stall_o),
  .rsp_valid_o (rsp_valid_o),
  .rsp_stall_i (rsp_stall_i),
  .rsp_o       (rsp_o)
);
